### rtl/core/signed_int_to_decimal_text_defines.svh
// Assertion macros shared by the decimal text converter modules.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SITDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SITDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sitdt_pkg.sv
// Types and constants for the signed integer to decimal text converter.
`default_nettype none

package sitdt_pkg;

  localparam int unsigned MagW     = 32;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned Digits   = 10;
  localparam int unsigned BcdW     = Digits * DigitW;
  localparam int unsigned BitCntW  = $clog2(MagW + 1);
  localparam int unsigned DigCntW  = $clog2(Digits + 1);
  localparam int unsigned CharW    = 8;

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharNine  = 8'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [DigitW-1:0] top_digit;
  } bcd_sts_t;

endpackage

`default_nettype wire

### rtl/core/sitdt_bcd.sv
// Bit-serial binary to BCD converter with a digit shift-out port.
`default_nettype none
`include "signed_int_to_decimal_text_defines.svh"

module sitdt_bcd
  import sitdt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bcd_ctrl_t       ctrl_i,
  input  wire logic [MagW-1:0] mag_i,
  output bcd_sts_t             sts_o
);

  logic [MagW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic [BcdW-1:0]    adj;

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitW'(3);
      end else begin
        adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = BitCntW'(MagW);
    end else if (cnt_q != '0) begin
      bcd_d = {adj[BcdW-2:0], bin_q[MagW-1]};
      bin_d = {bin_q[MagW-2:0], 1'b0};
      cnt_d = cnt_q - BitCntW'(1);
    end else if (ctrl_i.shift) begin
      bcd_d = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.done      = (cnt_q == '0);
  assign sts_o.top_digit = bcd_q[BcdW-1 -: DigitW];

  `SITDT_ASSERT_NEXT(a_load_starts, ctrl_i.load, cnt_q == BitCntW'(MagW), "load did not start")
  `SITDT_ASSERT_NOW(a_shift_when_done, ctrl_i.shift, cnt_q == '0, "shift during conversion")
  `SITDT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= BitCntW'(MagW), "bit counter out of range")

endmodule

`default_nettype wire

### rtl/core/signed_int_to_decimal_text.sv
// Top level: converts a signed 32-bit integer into its decimal ASCII text.
//
//   Channel   Direction  Payload (low bit first)         Marker
//   s_axis    in         tdata[31:0] value                none
//   m_axis    out        tdata[7:0] char_code             tlast = last
//
// Each value is taken in and passes through the bit-serial binary to BCD
// conversion; a minus sign follows for a negative value, and then the walk
// over the ten BCD digits (leading zeros are skipped without output).
// Reset is asynchronous and active low; there is nothing else to clear.
// A stalled output holds the walk; the next value is taken once the final
// character sits in the output register.
`default_nettype none
`include "signed_int_to_decimal_text_defines.svh"

module signed_int_to_decimal_text
  import sitdt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [MagW-1:0]  s_axis_tdata,   // [31:0] value
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [CharW-1:0]      m_axis_tdata,   // [7:0] char_code
  output logic                  m_axis_tlast
);

  state_e             state_q, state_d;
  logic               neg_q, neg_d;
  logic               started_q, started_d;
  logic [DigCntW-1:0] dig_q, dig_d;
  logic               ovalid_q, ovalid_d;
  logic [CharW-1:0]   ochar_q, ochar_d;
  logic               olast_q, olast_d;
  logic               slot_free;
  logic [MagW-1:0]    mag;
  bcd_ctrl_t          bcd_ctrl;
  bcd_sts_t           bcd_sts;
  logic               last_emit;
  logic               last_out;
  logic               char_ok;

  assign mag = s_axis_tdata[MagW-1] ? MagW'(~s_axis_tdata + MagW'(1)) : s_axis_tdata;
  assign slot_free = !ovalid_q || m_axis_tready;

  sitdt_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bcd_ctrl),
    .mag_i  (mag),
    .sts_o  (bcd_sts)
  );

  always_comb begin
    state_d       = state_q;
    neg_d         = neg_q;
    started_d     = started_q;
    dig_d         = dig_q;
    ovalid_d      = ovalid_q && !m_axis_tready;
    ochar_d       = ochar_q;
    olast_d       = olast_q;
    bcd_ctrl      = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d         = s_axis_tdata[MagW-1];
          bcd_ctrl.load = 1'b1;
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_sts.done) begin
          dig_d     = DigCntW'(Digits);
          started_d = 1'b0;
          state_d   = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = CharMinus;
          olast_d  = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_q && dig_q != DigCntW'(1) && bcd_sts.top_digit == '0) begin
          bcd_ctrl.shift = 1'b1;
          dig_d          = dig_q - DigCntW'(1);
        end else if (slot_free) begin
          ovalid_d       = 1'b1;
          ochar_d        = CharZero + CharW'(bcd_sts.top_digit);
          olast_d        = (dig_q == DigCntW'(1));
          bcd_ctrl.shift = 1'b1;
          started_d      = 1'b1;
          dig_d          = dig_q - DigCntW'(1);
          if (dig_q == DigCntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ovalid_q  <= 1'b0;
      started_q <= 1'b0;
      dig_q     <= '0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      started_q <= started_d;
      dig_q     <= dig_d;
      neg_q     <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ochar_q;
  assign m_axis_tlast  = olast_q;

  assign last_emit = (state_q == ST_EMIT) && slot_free && (dig_q == DigCntW'(1));
  assign last_out  = (state_q == ST_IDLE) && ovalid_q && olast_q;
  assign char_ok   = (ochar_q == CharMinus) || (ochar_q >= CharZero && ochar_q <= CharNine);

  `SITDT_ASSERT_NOW(a_idle_done, state_q == ST_IDLE, bcd_sts.done, "idle while converting")
  `SITDT_ASSERT_NOW(a_emit_digits, state_q == ST_EMIT, dig_q != '0, "no digits left in emit")
  `SITDT_ASSERT_NEXT(a_last_to_idle, last_emit, last_out, "final character not flagged")
  `SITDT_ASSERT_NOW(a_char_range, m_axis_tvalid, char_ok, "character out of range")

endmodule

`default_nettype wire
